FILE: hdl/c3kf_pkg.sv
// Shared types, constants and kernel tables of the 3x3 convolution filter.
package c3kf_pkg;

    // Default geometry limits
    localparam int K_MAX_WIDTH  = 1024;
    localparam int K_MAX_HEIGHT = 4096;

    // Field and register widths
    localparam int K_PIXEL_W    = 8;
    localparam int K_KIND_W     = 2;
    localparam int K_WIDTH_CW   = 11;
    localparam int K_HEIGHT_CW  = 13;
    localparam int K_CFG_DATA_W = 13;
    localparam int K_CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [K_KIND_W-1:0]    K_RST_KIND   = '0;
    localparam logic [K_PIXEL_W-1:0]   K_RST_MAX    = 8'd255;
    localparam logic [K_WIDTH_CW-1:0]  K_RST_WIDTH  = 11'd1024;
    localparam logic [K_HEIGHT_CW-1:0] K_RST_HEIGHT = 13'd1024;

    // Arithmetic widths: signed sum, positive sum, reciprocal, product
    localparam int K_SUM_W   = 14;
    localparam int K_POS_W   = 12;
    localparam int K_RECIP_W = 17;
    localparam int K_FRAC_W  = 16;
    localparam int K_PROD_W  = K_POS_W + K_RECIP_W;
    localparam int K_Q_W     = K_PROD_W - K_FRAC_W;
    localparam int K_WGT_W   = 5;

    // Configuration register indexes
    typedef enum logic [K_CFG_IDX_W-1:0] {
        CFG_FILTER_KIND  = 2'd0,
        CFG_MAX_PIXEL    = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_idx;

    // Kernel weights, row major: smooth, blur, sharpen, mean removal
    localparam logic signed [K_WGT_W-1:0] K_WEIGHTS [4][9] = '{
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
        '{ 5'sd0, -5'sd2,  5'sd0, -5'sd2, 5'sd11, -5'sd2,  5'sd0, -5'sd2,  5'sd0},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
    };

    // Reciprocals of the divisors 9, 16, 3, 1 scaled by 2^16; exact floor for sums below 4096
    localparam logic [K_RECIP_W-1:0] K_RECIP [4] = '{
        17'd7282, 17'd4096, 17'd21846, 17'd65536
    };

    // Input and result requests
    typedef struct packed {
        logic [K_PIXEL_W-1:0] pixel;
        logic                 flush;
    } t_in_req;

    typedef struct packed {
        logic [K_PIXEL_W-1:0] filtered_pixel;
        logic                 last_of_frame;
    } t_out_req;

    // Masked 3x3 neighborhood, row major
    typedef logic [8:0][K_PIXEL_W-1:0] t_nbhd;

    // Control carried along the arithmetic pipeline
    typedef struct packed {
        logic valid;
        logic has_res;
        logic last;
    } t_arith_ctl;

endpackage

FILE: hdl/c3kf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c3kf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: hdl/c3kf_arith.sv
// Weighted sum, exact division and clamp of a masked 3x3 neighborhood (5 stages).
module c3kf_arith (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c3kf_pkg::t_arith_ctl              i_ctl,
    input  c3kf_pkg::t_nbhd                   i_nbhd,
    input  logic [c3kf_pkg::K_KIND_W-1:0]     i_kind,
    input  logic [c3kf_pkg::K_PIXEL_W-1:0]    i_max,
    output c3kf_pkg::t_arith_ctl              o_ctl,
    output logic [c3kf_pkg::K_PIXEL_W-1:0]    o_pixel
);
    import c3kf_pkg::*;

    t_arith_ctl                  r_a_ctl, r_b_ctl, r_c_ctl, r_d_ctl, r_e_ctl;
    t_nbhd                       r_a_pix;
    logic signed [K_SUM_W-1:0]   r_b_row [3];
    logic signed [K_SUM_W-1:0]   n_b_row [3];
    logic signed [K_SUM_W-1:0]   r_c_sum;
    logic [K_PROD_W-1:0]         r_d_prod;
    logic                        r_d_pos;
    logic [K_PIXEL_W-1:0]        r_e_pix;
    logic [K_Q_W-1:0]            quot;
    logic [K_PIXEL_W-1:0]        n_e_pix;

    // control valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_e_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
            r_c_ctl <= r_b_ctl;
            r_d_ctl <= r_c_ctl;
            r_e_ctl <= r_d_ctl;
        end
    end

    // row sums: three small constant-table products each
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_b_row[r] = '0;
            for (int c = 0; c < 3; c++) begin
                n_b_row[r] = n_b_row[r] + K_SUM_W'($signed(K_WEIGHTS[i_kind][r*3+c])
                             * $signed({1'b0, r_a_pix[r*3+c]}));
            end
        end
    end

    // quotient, then zero floor and saturation
    always_comb begin
        quot = r_d_prod[K_PROD_W-1:K_FRAC_W];
        if (!r_d_pos) begin
            n_e_pix = '0;
        end else if (quot >= K_Q_W'(i_max)) begin
            n_e_pix = i_max;
        end else begin
            n_e_pix = quot[K_PIXEL_W-1:0];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_a_pix  <= i_nbhd;
        r_b_row  <= n_b_row;
        r_c_sum  <= r_b_row[0] + r_b_row[1] + r_b_row[2];
        r_d_pos  <= (r_c_sum > 0);
        r_d_prod <= K_PROD_W'(r_c_sum[K_POS_W-1:0]) * K_PROD_W'(K_RECIP[i_kind]);
        r_e_pix  <= n_e_pix;
    end

    assign o_ctl   = r_e_ctl;
    assign o_pixel = r_e_pix;

endmodule

FILE: hdl/conv3x3_kernel_filter.sv
// Top level of the streaming 3x3 convolution filter with fixed kernels.
//
// Input channel: i_in_valid / o_in_ready carry one grey pixel request in raster
// order, with a flush bit for the trailing border items. After the last pixel of a
// frame the source sends image_width+1 flush requests to push out the last row.
// Output channel: o_out_valid / i_out_ready carry one filtered pixel request, with
// last_of_frame on the final pixel of the image. Results lag the input stream by
// image_width+1 requests; the first item of each row past the second also closes
// the last column of the row two above.
// Throughput: one request per clock while o_in_ready is high. Both line stores share
// one RAM entry per column, read when the request is taken and written back in the
// next cycle, with a bypass for back-to-back hits on the same column (width of one).
// Path: a result is visible at the output after the request that completes it is
// taken and passes the RAM read, window, arithmetic stages and output queue.
// Stall: a 16-entry output queue absorbs the pipeline; o_in_ready drops only
// while 16 requests are taken but not yet delivered or retired.
// Reset: registers take their reset values, positions return to the frame start, the
// window clears; the line stores need no clearing pass since row masks hide every
// entry not yet written in the current frame. The user writes configuration via
// i_cfg_wr_en / i_cfg_index / i_cfg_data only while idle; not enforced in the block.
module conv3x3_kernel_filter #(
    parameter int MAX_WIDTH  = c3kf_pkg::K_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3kf_pkg::K_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  c3kf_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output c3kf_pkg::t_out_req                o_out_req,
    input  logic                              i_cfg_wr_en,
    input  c3kf_pkg::t_cfg_idx                i_cfg_index,
    input  logic [c3kf_pkg::K_CFG_DATA_W-1:0] i_cfg_data
);
    import c3kf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int EW  = RW + 1;
    localparam int WGW = (WW > K_WIDTH_CW) ? WW : K_WIDTH_CW;
    localparam int HGW = (HW > K_HEIGHT_CW) ? HW : K_HEIGHT_CW;
    localparam int FIFO_DEPTH = 16;
    localparam int FAW = $clog2(FIFO_DEPTH);
    localparam int LW  = 2 * K_PIXEL_W;

    // configuration registers
    logic [K_KIND_W-1:0]    r_cfg_kind;
    logic [K_PIXEL_W-1:0]   r_cfg_max;
    logic [K_WIDTH_CW-1:0]  r_cfg_width;
    logic [K_HEIGHT_CW-1:0] r_cfg_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_kind   <= K_RST_KIND;
            r_cfg_max    <= K_RST_MAX;
            r_cfg_width  <= K_RST_WIDTH;
            r_cfg_height <= K_RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FILTER_KIND:  r_cfg_kind   <= i_cfg_data[K_KIND_W-1:0];
                CFG_MAX_PIXEL:    r_cfg_max    <= i_cfg_data[K_PIXEL_W-1:0];
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[K_WIDTH_CW-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[K_HEIGHT_CW-1:0];
            endcase
        end
    end

    // effective geometry: zero acts as one, large values clip to the maxima
    logic [WGW-1:0] w_raw;
    logic [HGW-1:0] h_raw;
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;

    always_comb begin
        w_raw = WGW'(r_cfg_width);
        h_raw = HGW'(r_cfg_height);
        if (w_raw == '0) begin
            w_eff = WW'(1);
        end else if (w_raw > WGW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw[WW-1:0];
        end
        if (h_raw == '0) begin
            h_eff = HW'(1);
        end else if (h_raw > HGW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw[HW-1:0];
        end
    end

    // position, handshake and output queue state
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [FAW:0]   r_pend, n_pend;
    logic [FAW:0]   r_cnt;
    logic [FAW-1:0] r_head, r_tail;
    t_out_req       r_fifo [FIFO_DEPTH];

    logic acc;
    assign o_in_ready = (r_pend < (FAW+1)'(FIFO_DEPTH));
    assign acc        = i_in_valid && o_in_ready;

    // position decode of the incoming request
    logic [EW-1:0]        h_e, ir_x;
    logic                 restart, rs, md, acc_last, cok0, cok2;
    logic [CW-1:0]        ic;
    logic [RW-1:0]        ir;
    logic [K_PIXEL_W-1:0] pix_v;
    logic [2:0]           rok;
    logic [WW-1:0]        col_inc;

    always_comb begin
        h_e     = EW'(h_eff);
        restart = (WW'(r_col) >= w_eff) || (EW'(r_row) > h_e + EW'(1)) ||
                  ((EW'(r_row) == h_e + EW'(1)) && (r_col != '0));
        ic      = restart ? '0 : r_col;
        ir      = restart ? '0 : r_row;
        ir_x    = EW'(ir);
        rs      = (ic == '0) && (ir_x >= EW'(2));
        md      = (ic != '0) && (ir_x >= EW'(1));
        acc_last = rs && (ir_x == h_e + EW'(1));
        pix_v   = (i_in_req.flush || ir_x >= h_e) ? '0 : i_in_req.pixel;
        for (int k = 0; k < 3; k++) begin
            if (rs) begin
                rok[k] = (ir_x + EW'(k) >= EW'(3)) && (ir_x + EW'(k) < h_e + EW'(3));
            end else begin
                rok[k] = (ir_x + EW'(k) >= EW'(2)) && (ir_x + EW'(k) < h_e + EW'(2));
            end
        end
        cok0 = rs ? (w_eff >= WW'(2)) : (ic >= CW'(2));
        cok2 = !rs;
        // advance; the final result of the frame sends the position home
        col_inc = WW'(ic) + WW'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = ir + RW'(1);
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = ir;
        end
        if (acc_last) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // stage 1 registers: request waiting for its line-store entry
    logic                 r_s1_valid, r_s1_has, r_s1_last, r_s1_cok0, r_s1_cok2;
    logic [2:0]           r_s1_rok;
    logic [K_PIXEL_W-1:0] r_s1_v;
    logic [CW-1:0]        r_s1_addr;
    logic                 r_fwd_hit;
    logic [LW-1:0]        r_fwd_data;
    logic [LW-1:0]        ram_rdata, line_rd, line_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            r_fwd_hit  <= acc && r_s1_valid && (r_s1_addr == ic);
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= line_wr;
        if (acc) begin
            r_s1_has  <= rs || md;
            r_s1_last <= acc_last;
            r_s1_rok  <= rok;
            r_s1_cok0 <= cok0;
            r_s1_cok2 <= cok2;
            r_s1_v    <= pix_v;
            r_s1_addr <= ic;
        end
    end

    // line stores: upper in the high byte, middle in the low byte
    assign line_rd = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign line_wr = {line_rd[K_PIXEL_W-1:0], r_s1_v};

    c3kf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (line_wr),
        .i_re    (acc),
        .i_raddr (ic),
        .o_rdata (ram_rdata)
    );

    // window: the two older columns; the newest comes from the store and the current request
    logic [K_PIXEL_W-1:0] r_c1 [3];
    logic [K_PIXEL_W-1:0] r_c2 [3];
    logic [K_PIXEL_W-1:0] new_col [3];
    t_nbhd                nbhd;
    t_arith_ctl           s1_ctl, ar_ctl;
    logic [K_PIXEL_W-1:0] ar_pixel;

    always_comb begin
        new_col[0] = line_rd[LW-1:K_PIXEL_W];
        new_col[1] = line_rd[K_PIXEL_W-1:0];
        new_col[2] = r_s1_v;
        for (int r = 0; r < 3; r++) begin
            nbhd[r*3+0] = (r_s1_rok[r] && r_s1_cok0) ? r_c1[r] : '0;
            nbhd[r*3+1] = r_s1_rok[r] ? r_c2[r] : '0;
            nbhd[r*3+2] = (r_s1_rok[r] && r_s1_cok2) ? new_col[r] : '0;
        end
        s1_ctl.valid   = r_s1_valid;
        s1_ctl.has_res = r_s1_has;
        s1_ctl.last    = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_c1[r] <= '0;
                r_c2[r] <= '0;
            end
        end else if (r_s1_valid) begin
            r_c1 <= r_c2;
            r_c2 <= new_col;
        end
    end

    c3kf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_nbhd  (nbhd),
        .i_kind  (r_cfg_kind),
        .i_max   (r_cfg_max),
        .o_ctl   (ar_ctl),
        .o_pixel (ar_pixel)
    );

    // output queue and outstanding request count
    logic push, pop, drop;
    assign push = ar_ctl.valid && ar_ctl.has_res;
    assign drop = ar_ctl.valid && !ar_ctl.has_res;
    assign pop  = o_out_valid && i_out_ready;

    assign n_pend = r_pend + (FAW+1)'(acc) - (FAW+1)'(drop) - (FAW+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= r_cnt + (FAW+1)'(push) - (FAW+1)'(pop);
            if (push) begin
                r_tail <= r_tail + FAW'(1);
            end
            if (pop) begin
                r_head <= r_head + FAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_tail] <= '{filtered_pixel: ar_pixel, last_of_frame: ar_ctl.last};
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_req   = r_fifo[r_head];

    // checks
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < (FAW+1)'(FIFO_DEPTH)))
        else $error("output queue written while full");

    a_pend_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend <= (FAW+1)'(FIFO_DEPTH)) && (r_cnt <= r_pend))
        else $error("outstanding count lost track of queued results");

    a_frame_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && acc_last) |=> ((r_col == '0) && (r_row == '0)))
        else $error("position not returned to frame start after last result");

    a_fwd_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("store bypass taken with no request in the read stage");

endmodule
